// ===== rtl/shared_exclusive_lock_table_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the lock table core
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SHARED_EXCLUSIVE_LOCK_TABLE_CORE_ASSERT_SVH
`define SHARED_EXCLUSIVE_LOCK_TABLE_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define SELT_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define SELT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/selt_pkg.sv =====
// ----------------------------------------------------------------------------
// Lock table package
// Beat types, operation and status codes and fixed field widths.
// ----------------------------------------------------------------------------
package selt_pkg;

  localparam int OP_W     = 3;
  localparam int KEY_W    = 32;
  localparam int LEASE_W  = 31;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int IVAL_W   = 12;
  localparam int EXP_W    = 32;
  // Whole seconds of the largest lease in ms fit in this many bits.
  localparam int SECS_W   = 22;

  localparam logic [IVAL_W-1:0] SWEEP_INTERVAL_RST = 12'd10;

  localparam logic [OP_W-1:0] OP_ACQUIRE      = 3'd0;
  localparam logic [OP_W-1:0] OP_RELEASE      = 3'd1;
  localparam logic [OP_W-1:0] OP_RENEW        = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY_HELD   = 3'd3;
  localparam logic [OP_W-1:0] OP_FORCE_UNLOCK = 3'd4;
  localparam logic [OP_W-1:0] OP_TICK         = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_ARG   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   resource_key;
    logic               want_exclusive;
    logic [LEASE_W-1:0] lease_ms;
    logic [SLOT_W-1:0]  slot_handle;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic                is_held;
    logic [COUNT_W-1:0]  removed_count;
    logic [COUNT_W-1:0]  total_count;
    logic [COUNT_W-1:0]  shared_count;
    logic [COUNT_W-1:0]  exclusive_count;
  } out_beat_t;

endpackage

// ===== rtl/selt_ms_to_s.sv =====
// ----------------------------------------------------------------------------
// Milliseconds to seconds converter
// Divides a lease in ms by 1000 with a registered reciprocal multiply.
// ----------------------------------------------------------------------------
module selt_ms_to_s (
  input  logic                          clk,
  input  logic [selt_pkg::LEASE_W-1:0]  lease_ms,
  output logic [selt_pkg::SECS_W-1:0]   secs
);

  // x / 1000 == (x >> 3) / 125. The reciprocal of 125 scaled by 2^35 and
  // rounded up is exact for every 28-bit dividend.
  localparam int DIVIDEND_W  = selt_pkg::LEASE_W - 3;
  localparam int MULT_W      = 29;
  localparam int RECIP_SHIFT = 35;
  localparam logic [MULT_W-1:0] RECIP_MULT = 29'd274877907;

  logic [DIVIDEND_W+MULT_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= lease_ms[selt_pkg::LEASE_W-1:3] * RECIP_MULT;
  end

  assign secs = prod_r[RECIP_SHIFT +: selt_pkg::SECS_W];

endmodule

// ===== rtl/shared_exclusive_lock_table_core.sv =====
// ----------------------------------------------------------------------------
// Shared/exclusive lock table core
// A table of lock entries with leases. One input beat carries an acquire,
// release, renew, held query, force unlock or one-second tick; every beat
// yields exactly one result beat with a status and the table's counts.
// Both channels use valid/ready; the one configuration register (sweep
// interval in ticks) is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while idle, and the core does not enforce this.
// Key, mode and expiry live in a one-port-write, one-port-read memory;
// valid bits and the counts sit in flip-flops. Scanning ops read every
// entry, then a granted acquire writes its entry; release and renew check
// their slot, then act on it unless rejected; a tick without a sweep or an
// unknown op goes straight to its result. The scan reads one entry a cycle
// through the memory; no new beat is taken before the sequencer is idle.
// Reset clears all valid bits, the counts, the seconds counter and the sweep
// countdown at once and holds in_ready low; no clearing pass runs. A finished
// result waits in the output register while the next input beat is already
// taken; a stalled receiver holds the core only when a second result is ready.
// ----------------------------------------------------------------------------
`include "shared_exclusive_lock_table_core_assert.svh"

module shared_exclusive_lock_table_core #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  selt_pkg::in_beat_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output selt_pkg::out_beat_t               out_data,
  input  logic                              cfg_wr_en,
  input  logic [selt_pkg::IVAL_W-1:0]       cfg_wr_data
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int EXP_W = selt_pkg::EXP_W;
  localparam int MEM_W = KEY_BITS + 1 + EXP_W;
  localparam logic [IDX_W:0] ENTRIES_C = (IDX_W + 1)'(ENTRIES);

  // Sequencer states.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_COMMIT   = 3'd2;
  localparam logic [2:0] S_SLOT     = 3'd3;
  localparam logic [2:0] S_SLOT_ACT = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  // Adds whole seconds to an expiry, saturating at the all-ones second.
  function automatic logic [EXP_W-1:0] sat_add(input logic [EXP_W-1:0] base,
                                               input logic [selt_pkg::SECS_W-1:0] add);
    logic [EXP_W:0] sum;
    sum = {1'b0, base} + (EXP_W + 1)'(add);
    return sum[EXP_W] ? {EXP_W{1'b1}} : sum[EXP_W-1:0];
  endfunction

  // Control state.
  logic [2:0]                     state_r, state_nxt;
  logic [IDX_W:0]                 scan_idx_r, scan_idx_nxt;
  logic                           chk_pend_r, chk_pend_nxt;
  logic [IDX_W-1:0]               chk_idx_r, chk_idx_nxt;
  logic                           conflict_r, conflict_nxt;
  logic                           free_found_r, free_found_nxt;
  logic [IDX_W-1:0]               free_idx_r, free_idx_nxt;
  logic                           held_r, held_nxt;
  logic [selt_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [selt_pkg::SLOT_W-1:0]    granted_r, granted_nxt;
  logic [CNT_W-1:0]               removed_r, removed_nxt;
  logic [ENTRIES-1:0]             valid_r, valid_nxt;
  logic [CNT_W-1:0]               total_r, total_nxt;
  logic [CNT_W-1:0]               shared_r, shared_nxt;
  logic [CNT_W-1:0]               excl_r, excl_nxt;
  logic [EXP_W-1:0]               now_r, now_nxt;
  logic [selt_pkg::IVAL_W-1:0]    countdown_r, countdown_nxt;
  logic [selt_pkg::IVAL_W-1:0]    interval_r, interval_nxt;
  logic                           out_valid_r, out_valid_nxt;

  // Payload registers.
  selt_pkg::in_beat_t             cmd_r;
  selt_pkg::out_beat_t            out_data_r;
  logic                           load_out;

  // Entry memory: key, exclusive flag and expiry second per slot.
  logic [MEM_W-1:0]               mem [ENTRIES];
  logic [MEM_W-1:0]               rd_data_r;
  logic [IDX_W-1:0]               rd_addr;
  logic                           mem_we;
  logic [IDX_W-1:0]               mem_waddr;
  logic [MEM_W-1:0]               mem_wdata;

  logic [selt_pkg::SECS_W-1:0]    lease_secs;
  logic [KEY_BITS-1:0]            cmd_key;
  logic [KEY_BITS-1:0]            chk_key;
  logic                           chk_excl;
  logic [EXP_W-1:0]               chk_exp;
  logic                           chk_valid;
  logic                           key_hit;
  logic                           drop;
  logic [IDX_W-1:0]               slot_idx;
  logic                           slot_ok;
  logic [selt_pkg::IVAL_W:0]      tick_cnt;

  selt_ms_to_s u_ms_to_s (
    .clk      (clk),
    .lease_ms (cmd_r.lease_ms),
    .secs     (lease_secs)
  );

  // No beat is taken while reset is held.
  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Keys are kept at KEY_BITS; a narrower table drops the upper key bits.
  assign cmd_key   = KEY_BITS'(cmd_r.resource_key);
  assign chk_key   = rd_data_r[MEM_W-1 -: KEY_BITS];
  assign chk_excl  = rd_data_r[EXP_W];
  assign chk_exp   = rd_data_r[EXP_W-1:0];
  assign chk_valid = valid_r[chk_idx_r];
  assign key_hit   = (chk_key == cmd_key);
  assign slot_idx  = IDX_W'(cmd_r.slot_handle);
  assign slot_ok   = (32'(cmd_r.slot_handle) < ENTRIES) && valid_r[slot_idx];
  assign tick_cnt  = {1'b0, countdown_r} + (selt_pkg::IVAL_W + 1)'(1);

  // The scan reads the entry the sequencer points at; slot ops read their slot.
  assign rd_addr = (state_r == S_SCAN) ? scan_idx_r[IDX_W-1:0] : slot_idx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    chk_pend_nxt   = chk_pend_r;
    chk_idx_nxt    = chk_idx_r;
    conflict_nxt   = conflict_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    held_nxt       = held_r;
    status_nxt     = status_r;
    granted_nxt    = granted_r;
    removed_nxt    = removed_r;
    valid_nxt      = valid_r;
    total_nxt      = total_r;
    shared_nxt     = shared_r;
    excl_nxt       = excl_r;
    now_nxt        = now_r;
    countdown_nxt  = countdown_r;
    interval_nxt   = interval_r;
    out_valid_nxt  = out_valid_r;
    load_out       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = free_idx_r;
    mem_wdata      = {cmd_key, cmd_r.want_exclusive, {EXP_W{1'b0}}};
    drop           = 1'b0;

    if (cfg_wr_en) begin
      interval_nxt = cfg_wr_data;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt     = selt_pkg::ST_OK;
          granted_nxt    = '0;
          held_nxt       = 1'b0;
          removed_nxt    = '0;
          scan_idx_nxt   = '0;
          chk_pend_nxt   = 1'b0;
          conflict_nxt   = 1'b0;
          free_found_nxt = 1'b0;
          unique case (in_data.op) inside
            selt_pkg::OP_ACQUIRE, selt_pkg::OP_QUERY_HELD,
            selt_pkg::OP_FORCE_UNLOCK: begin
              state_nxt = S_SCAN;
            end
            selt_pkg::OP_RELEASE, selt_pkg::OP_RENEW: begin
              state_nxt = S_SLOT;
            end
            selt_pkg::OP_TICK: begin
              // The sweep compares against the time after this tick.
              now_nxt = now_r + EXP_W'(1);
              if (tick_cnt >= {1'b0, interval_r}) begin
                countdown_nxt = '0;
                state_nxt     = S_SCAN;
              end else begin
                countdown_nxt = tick_cnt[selt_pkg::IVAL_W-1:0];
                state_nxt     = S_DONE;
              end
            end
            default: begin
              status_nxt = selt_pkg::ST_BAD_ARG;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one read a cycle; each entry is checked in the cycle after its read.
        if (scan_idx_r < ENTRIES_C) begin
          scan_idx_nxt = scan_idx_r + (IDX_W + 1)'(1);
          chk_pend_nxt = 1'b1;
          chk_idx_nxt  = scan_idx_r[IDX_W-1:0];
        end else begin
          chk_pend_nxt = 1'b0;
        end
        if (chk_pend_r) begin
          case (cmd_r.op)
            selt_pkg::OP_ACQUIRE: begin
              if (chk_valid) begin
                if (key_hit && (cmd_r.want_exclusive || chk_excl)) begin
                  conflict_nxt = 1'b1;
                end
              end else if (!free_found_r) begin
                free_found_nxt = 1'b1;
                free_idx_nxt   = chk_idx_r;
              end
            end
            selt_pkg::OP_QUERY_HELD: begin
              if (chk_valid && key_hit) begin
                held_nxt = 1'b1;
              end
            end
            selt_pkg::OP_FORCE_UNLOCK: begin
              drop = chk_valid && key_hit;
            end
            selt_pkg::OP_TICK: begin
              drop = chk_valid && (chk_exp != '0) && (chk_exp < now_r);
            end
            default: begin
              drop = 1'b0;
            end
          endcase
        end
        if (drop) begin
          valid_nxt[chk_idx_r] = 1'b0;
          removed_nxt = removed_r + CNT_W'(1);
          total_nxt   = total_r - CNT_W'(1);
          if (chk_excl) begin
            excl_nxt = excl_r - CNT_W'(1);
          end else begin
            shared_nxt = shared_r - CNT_W'(1);
          end
        end
        if ((scan_idx_r == ENTRIES_C) && !chk_pend_r) begin
          state_nxt = (cmd_r.op == selt_pkg::OP_ACQUIRE) ? S_COMMIT : S_DONE;
        end
      end

      S_COMMIT: begin
        // Conflicts take precedence over a full table.
        if (conflict_r) begin
          status_nxt = selt_pkg::ST_BUSY;
        end else if (!free_found_r) begin
          status_nxt = selt_pkg::ST_FULL;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = free_idx_r;
          mem_wdata = {cmd_key, cmd_r.want_exclusive,
                       (cmd_r.lease_ms != '0) ? sat_add(now_r, lease_secs)
                                              : {EXP_W{1'b0}}};
          valid_nxt[free_idx_r] = 1'b1;
          total_nxt   = total_r + CNT_W'(1);
          granted_nxt = selt_pkg::SLOT_W'(free_idx_r);
          if (cmd_r.want_exclusive) begin
            excl_nxt = excl_r + CNT_W'(1);
          end else begin
            shared_nxt = shared_r + CNT_W'(1);
          end
        end
        state_nxt = S_DONE;
      end

      S_SLOT: begin
        // A zero renew extension is rejected before the slot is looked at.
        if ((cmd_r.op == selt_pkg::OP_RENEW) && (cmd_r.lease_ms == '0)) begin
          status_nxt = selt_pkg::ST_BAD_ARG;
          state_nxt  = S_DONE;
        end else if (!slot_ok) begin
          status_nxt = selt_pkg::ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SLOT_ACT;
        end
      end

      S_SLOT_ACT: begin
        if (cmd_r.op == selt_pkg::OP_RELEASE) begin
          valid_nxt[slot_idx] = 1'b0;
          total_nxt = total_r - CNT_W'(1);
          if (chk_excl) begin
            excl_nxt = excl_r - CNT_W'(1);
          end else begin
            shared_nxt = shared_r - CNT_W'(1);
          end
        end else if (chk_exp != '0) begin
          // Entries that never expire are left as they are.
          mem_we    = 1'b1;
          mem_waddr = slot_idx;
          mem_wdata = {chk_key, chk_excl, sat_add(chk_exp, lease_secs)};
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          load_out      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_idx_r   <= '0;
      chk_pend_r   <= 1'b0;
      chk_idx_r    <= '0;
      conflict_r   <= 1'b0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      held_r       <= 1'b0;
      status_r     <= selt_pkg::ST_OK;
      granted_r    <= '0;
      removed_r    <= '0;
      valid_r      <= '0;
      total_r      <= '0;
      shared_r     <= '0;
      excl_r       <= '0;
      now_r        <= '0;
      countdown_r  <= '0;
      interval_r   <= selt_pkg::SWEEP_INTERVAL_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_idx_r   <= scan_idx_nxt;
      chk_pend_r   <= chk_pend_nxt;
      chk_idx_r    <= chk_idx_nxt;
      conflict_r   <= conflict_nxt;
      free_found_r <= free_found_nxt;
      free_idx_r   <= free_idx_nxt;
      held_r       <= held_nxt;
      status_r     <= status_nxt;
      granted_r    <= granted_nxt;
      removed_r    <= removed_nxt;
      valid_r      <= valid_nxt;
      total_r      <= total_nxt;
      shared_r     <= shared_nxt;
      excl_r       <= excl_nxt;
      now_r        <= now_nxt;
      countdown_r  <= countdown_nxt;
      interval_r   <= interval_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_data;
    end
    if (load_out) begin
      out_data_r.status          <= status_r;
      out_data_r.granted_slot    <= granted_r;
      out_data_r.is_held         <= held_r;
      out_data_r.removed_count   <= selt_pkg::COUNT_W'(removed_r);
      out_data_r.total_count     <= selt_pkg::COUNT_W'(total_r);
      out_data_r.shared_count    <= selt_pkg::COUNT_W'(shared_r);
      out_data_r.exclusive_count <= selt_pkg::COUNT_W'(excl_r);
    end
  end

  // The running counts must always agree with the valid bits.
  `SELT_ASSERT_ALWAYS(a_count_split, clk, rst_n, total_r == (shared_r + excl_r),
                      "total count differs from shared plus exclusive")
  `SELT_ASSERT_ALWAYS(a_count_valid, clk, rst_n, $countones(valid_r) == total_r,
                      "total count differs from the number of valid entries")
  `SELT_ASSERT_NEXT(a_busy_no_change, clk, rst_n, (state_r == S_COMMIT) && conflict_r,
                    $stable(valid_r), "busy acquire changed the table")
  `SELT_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready,
                    state_r != S_IDLE, "sequencer stayed idle after an input beat")

endmodule
